// ===== src/arx_pkg.sv =====
`timescale 1ns / 1ps

package arx_pkg;

  localparam int SAMPLE_W   = 16;
  localparam int COEF_W     = 16;
  localparam int PROD_W     = SAMPLE_W + COEF_W;
  localparam int FRAC_SHIFT = 12;
  localparam int DELAY_W    = 3;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;

  // coefficient registers that exist per tap group
  localparam int FB_REGS = 3;
  localparam int FF_REGS = 3;

  localparam int FB_TAPS_DEF   = 3;
  localparam int FF_TAPS_DEF   = 3;
  localparam int MAX_DELAY_DEF = 7;

  // register indexes on the configuration port
  localparam logic [CFG_IDX_W-1:0] REG_FB_COEF_1   = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_FF_COEF_0   = CFG_IDX_W'(3);
  localparam logic [CFG_IDX_W-1:0] REG_INPUT_DELAY = CFG_IDX_W'(6);

  typedef logic signed [SAMPLE_W-1:0] sample_t;
  typedef logic signed [COEF_W-1:0]   coef_t;

  typedef struct packed {
    sample_t y_sample;
    logic    clipped;
  } arx_result_t;

endpackage

// ===== src/arx_model_step.sv =====
`timescale 1ns / 1ps

// an accepted request's result is registered in the output buffer (output slot or skid entry)
// throughput: one request per cycle while in_stall is low; the y(i-1) feedback product, sum,
//   round and saturate are combinational, closing through the output history cells
// a two-entry output buffer keeps in_stall low while one result waits downstream
// reset (rst_n low, synchronous) clears both sample histories, all coefficients,
//   the delay register and the output buffer; no clearing pass is needed
module arx_model_step #(
  parameter int FB_TAPS   = arx_pkg::FB_TAPS_DEF,
  parameter int FF_TAPS   = arx_pkg::FF_TAPS_DEF,
  parameter int MAX_DELAY = arx_pkg::MAX_DELAY_DEF
) (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [arx_pkg::SAMPLE_W-1:0] in_u_sample,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic signed [arx_pkg::SAMPLE_W-1:0] out_y_sample,
  output logic                                out_clipped,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [arx_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [arx_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int HIST_DEPTH = MAX_DELAY + FF_TAPS;
  localparam int IN_CELLS   = (HIST_DEPTH > 1) ? HIST_DEPTH - 1 : 1;
  localparam int K_W        = (MAX_DELAY > 0) ? $clog2(MAX_DELAY + 1) : 1;
  localparam int IDX_W      = (HIST_DEPTH > 1) ? $clog2(HIST_DEPTH) : 1;

  arx_pkg::coef_t               fb_coef_r [FB_TAPS];
  arx_pkg::coef_t               ff_coef_r [FF_TAPS];
  logic [arx_pkg::DELAY_W-1:0]  input_delay_r;
  logic                         cfg_wr;
  logic                         accept;
  logic [K_W-1:0]               k;
  arx_pkg::sample_t             view      [HIST_DEPTH];
  arx_pkg::sample_t             in_cell_q [IN_CELLS];
  arx_pkg::sample_t             fb_cell_q [FB_TAPS];
  arx_pkg::sample_t             ff_smp    [FF_TAPS];
  arx_pkg::arx_result_t         mac_res;
  arx_pkg::arx_result_t         buf_res;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;
  assign accept    = in_valid && !in_stall;

  // taps without a register stay at zero; unknown indexes fall through
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int j = 0; j < FB_TAPS; j++) begin
        fb_coef_r[j] <= '0;
      end
      for (int j = 0; j < FF_TAPS; j++) begin
        ff_coef_r[j] <= '0;
      end
      input_delay_r <= '0;
    end else if (cfg_wr) begin
      for (int j = 0; j < FB_TAPS; j++) begin
        if (j < arx_pkg::FB_REGS &&
            cfg_index == arx_pkg::REG_FB_COEF_1 + arx_pkg::CFG_IDX_W'(j)) begin
          fb_coef_r[j] <= cfg_wdata;
        end
      end
      for (int j = 0; j < FF_TAPS; j++) begin
        if (j < arx_pkg::FF_REGS &&
            cfg_index == arx_pkg::REG_FF_COEF_0 + arx_pkg::CFG_IDX_W'(j)) begin
          ff_coef_r[j] <= cfg_wdata;
        end
      end
      if (cfg_index == arx_pkg::REG_INPUT_DELAY) begin
        input_delay_r <= cfg_wdata[arx_pkg::DELAY_W-1:0];
      end
    end
  end

  always_comb begin
    if (32'(input_delay_r) > MAX_DELAY) begin
      k = K_W'(MAX_DELAY);
    end else begin
      k = K_W'(input_delay_r);
    end
  end

  // input history as seen after this request shifts in: entry 0 is the new sample
  assign view[0] = in_u_sample;

  for (genvar c = 1; c < HIST_DEPTH; c++) begin : g_view
    assign view[c] = in_cell_q[c-1];
  end

  for (genvar c = 0; c < IN_CELLS; c++) begin : g_in_cell
    arx_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift   (accept),
      .smp_in  (view[c]),
      .smp_out (in_cell_q[c])
    );
  end

  always_comb begin
    for (int j = 0; j < FF_TAPS; j++) begin
      ff_smp[j] = view[IDX_W'(k) + IDX_W'(j)];
    end
  end

  // output history: cell 0 holds y(i-1)
  for (genvar c = 0; c < FB_TAPS; c++) begin : g_fb_cell
    if (c == 0) begin : g_head
      arx_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (accept),
        .smp_in  (mac_res.y_sample),
        .smp_out (fb_cell_q[c])
      );
    end else begin : g_body
      arx_cell u_cell (
        .clk     (clk),
        .rst_n   (rst_n),
        .shift   (accept),
        .smp_in  (fb_cell_q[c-1]),
        .smp_out (fb_cell_q[c])
      );
    end
  end

  arx_mac #(
    .FF_TAPS (FF_TAPS),
    .FB_TAPS (FB_TAPS)
  ) u_mac (
    .ff_smp  (ff_smp),
    .ff_coef (ff_coef_r),
    .fb_smp  (fb_cell_q),
    .fb_coef (fb_coef_r),
    .res     (mac_res)
  );

  arx_out_buf u_out_buf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (accept),
    .push_res  (mac_res),
    .full      (in_stall),
    .out_valid (out_valid),
    .out_res   (buf_res),
    .out_stall (out_stall)
  );

  assign out_y_sample = buf_res.y_sample;
  assign out_clipped  = buf_res.clipped;

endmodule

// ===== src/arx_cell.sv =====
`timescale 1ns / 1ps

module arx_cell (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             shift,
  input  arx_pkg::sample_t smp_in,
  output arx_pkg::sample_t smp_out
);

  arx_pkg::sample_t smp_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      smp_r <= '0;
    end else if (shift) begin
      smp_r <= smp_in;
    end
  end

  assign smp_out = smp_r;

endmodule

// ===== src/arx_mac.sv =====
`timescale 1ns / 1ps

module arx_mac #(
  parameter int FF_TAPS = arx_pkg::FF_TAPS_DEF,
  parameter int FB_TAPS = arx_pkg::FB_TAPS_DEF
) (
  input  arx_pkg::sample_t    ff_smp  [FF_TAPS],
  input  arx_pkg::coef_t      ff_coef [FF_TAPS],
  input  arx_pkg::sample_t    fb_smp  [FB_TAPS],
  input  arx_pkg::coef_t      fb_coef [FB_TAPS],
  output arx_pkg::arx_result_t res
);

  localparam int ACC_W = arx_pkg::PROD_W + $clog2(FF_TAPS + FB_TAPS) + 1;
  localparam int RND_W = ACC_W - arx_pkg::FRAC_SHIFT;
  localparam logic signed [ACC_W-1:0] ROUND_HALF =
    ACC_W'(1 << (arx_pkg::FRAC_SHIFT - 1));
  localparam logic signed [RND_W-1:0] Y_MAX = RND_W'((1 << (arx_pkg::SAMPLE_W - 1)) - 1);
  localparam logic signed [RND_W-1:0] Y_MIN = RND_W'(-(1 << (arx_pkg::SAMPLE_W - 1)));

  logic signed [arx_pkg::PROD_W-1:0] ff_prod [FF_TAPS];
  logic signed [arx_pkg::PROD_W-1:0] fb_prod [FB_TAPS];
  logic signed [ACC_W-1:0]           acc;
  logic signed [ACC_W-1:0]           acc_rnd;
  logic signed [RND_W-1:0]           y_full;

  always_comb begin
    for (int j = 0; j < FF_TAPS; j++) begin
      ff_prod[j] = ff_smp[j] * ff_coef[j];
    end
    for (int j = 0; j < FB_TAPS; j++) begin
      fb_prod[j] = fb_smp[j] * fb_coef[j];
    end
  end

  always_comb begin
    acc = '0;
    for (int j = 0; j < FF_TAPS; j++) begin
      acc = acc + ACC_W'(ff_prod[j]);
    end
    for (int j = 0; j < FB_TAPS; j++) begin
      acc = acc - ACC_W'(fb_prod[j]);
    end
  end

  // round half up, then floor back to q1.15
  assign acc_rnd = acc + ROUND_HALF;
  assign y_full  = $signed(acc_rnd[ACC_W-1:arx_pkg::FRAC_SHIFT]);

  always_comb begin
    if (y_full > Y_MAX) begin
      res.y_sample = Y_MAX[arx_pkg::SAMPLE_W-1:0];
      res.clipped  = 1'b1;
    end else if (y_full < Y_MIN) begin
      res.y_sample = Y_MIN[arx_pkg::SAMPLE_W-1:0];
      res.clipped  = 1'b1;
    end else begin
      res.y_sample = y_full[arx_pkg::SAMPLE_W-1:0];
      res.clipped  = 1'b0;
    end
  end

endmodule

// ===== src/arx_out_buf.sv =====
`timescale 1ns / 1ps

module arx_out_buf (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  input  arx_pkg::arx_result_t push_res,
  output logic                 full,
  output logic                 out_valid,
  output arx_pkg::arx_result_t out_res,
  input  logic                 out_stall
);

  logic                 out_valid_r, out_valid_nxt;
  logic                 skid_valid_r, skid_valid_nxt;
  arx_pkg::arx_result_t out_res_r, out_res_nxt;
  arx_pkg::arx_result_t skid_res_r, skid_res_nxt;
  logic                 pop;

  assign pop = out_valid_r && !out_stall;

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_res_nxt    = out_res_r;
    skid_valid_nxt = skid_valid_r;
    skid_res_nxt   = skid_res_r;
    if (!out_valid_r || pop) begin
      // output slot frees up: oldest pending request moves in
      out_valid_nxt  = skid_valid_r || push;
      out_res_nxt    = skid_valid_r ? skid_res_r : push_res;
      skid_valid_nxt = skid_valid_r && push;
      if (skid_valid_r) begin
        skid_res_nxt = push_res;
      end
    end else if (push) begin
      skid_valid_nxt = 1'b1;
      skid_res_nxt   = push_res;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_res_r  <= out_res_nxt;
    skid_res_r <= skid_res_nxt;
  end

  assign full      = skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held while output slot empty");

  a_held_push_to_skid: assert property (@(posedge clk) disable iff (!rst_n)
    (push && out_valid_r && !pop) |=> skid_valid_r)
    else $error("request lost while output stalled");

  a_drain_empties: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !skid_valid_r && !push) |=> !out_valid_r)
    else $error("result repeated after drain");

endmodule

// ===== tb/arx_output_checker.sv =====
`timescale 1ns / 1ps

module arx_output_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  input  logic                           in_stall,
  input  arx_pkg::sample_t               in_u_sample,
  input  logic                           out_valid,
  input  logic                           out_stall,
  input  arx_pkg::sample_t               out_y_sample,
  input  logic                           out_clipped,
  input  logic                           cfg_valid,
  input  logic                           cfg_ready,
  input  logic [arx_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [arx_pkg::CFG_DATA_W-1:0] cfg_wdata,
  output int                             mismatch_cnt,
  output int                             y_waiting
);

  localparam int     HIST_LEN = arx_pkg::MAX_DELAY_DEF + arx_pkg::FF_TAPS_DEF;
  localparam longint Y_MAX    = 2 ** (arx_pkg::SAMPLE_W - 1) - 1;
  localparam longint Y_MIN    = -(2 ** (arx_pkg::SAMPLE_W - 1));

  arx_pkg::coef_t              fb_coef [arx_pkg::FB_REGS];
  arx_pkg::coef_t              ff_coef [arx_pkg::FF_REGS];
  logic [arx_pkg::DELAY_W-1:0] delay_k;
  arx_pkg::sample_t            u_hist [HIST_LEN];
  arx_pkg::sample_t            y_hist [arx_pkg::FB_TAPS_DEF];
  arx_pkg::arx_result_t        expected_y_q [$];
  arx_pkg::arx_result_t        want_r;
  int                          errs = 0;

  // one step of the difference equation; shifts both histories
  function automatic arx_pkg::arx_result_t filter_step(input arx_pkg::sample_t u);
    longint               acc;
    longint               y_wide;
    int                   k;
    int                   i;
    arx_pkg::arx_result_t r;
    k = (delay_k > arx_pkg::MAX_DELAY_DEF) ? arx_pkg::MAX_DELAY_DEF : int'(delay_k);
    for (i = HIST_LEN - 1; i > 0; i--) u_hist[i] = u_hist[i - 1];
    u_hist[0] = u;
    acc = 0;
    for (i = 0; i < arx_pkg::FF_TAPS_DEF; i++)
      acc += longint'(ff_coef[i]) * longint'(u_hist[k + i]);
    for (i = 0; i < arx_pkg::FB_TAPS_DEF; i++)
      acc -= longint'(fb_coef[i]) * longint'(y_hist[i]);
    // half an lsb up, then floor: ties go toward plus infinity
    y_wide = (acc + (longint'(1) << (arx_pkg::FRAC_SHIFT - 1))) >>> arx_pkg::FRAC_SHIFT;
    r.clipped = 1'b0;
    if (y_wide > Y_MAX) begin
      y_wide    = Y_MAX;
      r.clipped = 1'b1;
    end else if (y_wide < Y_MIN) begin
      y_wide    = Y_MIN;
      r.clipped = 1'b1;
    end
    r.y_sample = arx_pkg::sample_t'(y_wide);
    for (i = arx_pkg::FB_TAPS_DEF - 1; i > 0; i--) y_hist[i] = y_hist[i - 1];
    y_hist[0] = r.y_sample;
    return r;
  endfunction

  always @(posedge clk) begin
    if (!rst_n) begin
      foreach (fb_coef[i]) fb_coef[i] = '0;
      foreach (ff_coef[i]) ff_coef[i] = '0;
      foreach (u_hist[i]) u_hist[i] = '0;
      foreach (y_hist[i]) y_hist[i] = '0;
      delay_k = '0;
      expected_y_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        if (cfg_index < arx_pkg::REG_FF_COEF_0) begin
          fb_coef[cfg_index - arx_pkg::REG_FB_COEF_1] = arx_pkg::coef_t'(cfg_wdata);
        end else if (cfg_index < arx_pkg::REG_INPUT_DELAY) begin
          ff_coef[cfg_index - arx_pkg::REG_FF_COEF_0] = arx_pkg::coef_t'(cfg_wdata);
        end else if (cfg_index == arx_pkg::REG_INPUT_DELAY) begin
          delay_k = cfg_wdata[arx_pkg::DELAY_W-1:0];
        end
      end
      if (in_valid && !in_stall) expected_y_q.push_back(filter_step(in_u_sample));
      if (out_valid && !out_stall) begin
        if (expected_y_q.size() == 0) begin
          errs++;
          $display("%0t: unexpected result y_sample=%0d clipped=%0b", $time,
                   out_y_sample, out_clipped);
        end else begin
          want_r = expected_y_q.pop_front();
          if (out_y_sample !== want_r.y_sample) begin
            errs++;
            $display("%0t: y_sample expected %0d actual %0d", $time, want_r.y_sample,
                     out_y_sample);
          end
          if (out_clipped !== want_r.clipped) begin
            errs++;
            $display("%0t: clipped expected %0b actual %0b", $time, want_r.clipped,
                     out_clipped);
          end
        end
      end
    end
    mismatch_cnt <= errs;
    y_waiting    <= expected_y_q.size();
  end

endmodule

// ===== tb/arx_model_step_tb.sv =====
`timescale 1ns / 1ps

module arx_model_step_tb;

  localparam logic [arx_pkg::CFG_IDX_W-1:0] REG_NONE =
    arx_pkg::REG_INPUT_DELAY + arx_pkg::CFG_IDX_W'(1);
  localparam int      HOLD_CYCLES = 60;
  localparam int      PHASE_ITEMS = 140;
  localparam int      PAD_W       = arx_pkg::CFG_DATA_W - arx_pkg::DELAY_W;
  localparam arx_pkg::sample_t S_MAX = 16'sh7fff;
  localparam arx_pkg::sample_t S_MIN = 16'sh8000;
  localparam arx_pkg::coef_t   C_MAX = 16'sh7fff;
  localparam arx_pkg::coef_t   C_MIN = 16'sh8000;
  localparam arx_pkg::coef_t   C_ONE = 16'sh1000;

  logic                           clk         = 1'b0;
  logic                           rst_n       = 1'b0;
  logic                           in_valid    = 1'b0;
  arx_pkg::sample_t               in_u_sample = '0;
  logic                           out_stall   = 1'b0;
  logic                           cfg_valid   = 1'b0;
  logic [arx_pkg::CFG_IDX_W-1:0]  cfg_index   = '0;
  logic [arx_pkg::CFG_DATA_W-1:0] cfg_wdata   = '0;
  logic                           in_stall;
  logic                           out_valid;
  arx_pkg::sample_t               out_y_sample;
  logic                           out_clipped;
  logic                           cfg_ready;
  int                             mismatch_cnt;
  int                             y_waiting;

  int                             src_idle_pct   = 0;
  int                             sink_stall_pct = 0;
  int                             hold_req       = 0;
  int                             hold_ack       = 0;
  int                             hold_left      = 0;
  arx_pkg::coef_t                 fb_set [arx_pkg::FB_REGS];
  arx_pkg::coef_t                 ff_set [arx_pkg::FF_REGS];
  logic [arx_pkg::DELAY_W-1:0]    delay_set;

  always #4 clk = ~clk;

  arx_model_step u_dut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_u_sample  (in_u_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_y_sample (out_y_sample),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  arx_output_checker u_chk (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_u_sample  (in_u_sample),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_y_sample (out_y_sample),
    .out_clipped  (out_clipped),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata),
    .mismatch_cnt (mismatch_cnt),
    .y_waiting    (y_waiting)
  );

  // receiver: random stall, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != hold_ack) begin
      out_stall <= 1'b1;
      hold_ack  <= hold_req;
      hold_left <= HOLD_CYCLES;
    end else begin
      out_stall <= ($urandom_range(99) < sink_stall_pct);
    end
  end

  function automatic arx_pkg::sample_t rand_sample();
    case ($urandom_range(7))
      0:       return S_MAX;
      1:       return S_MIN;
      default: return arx_pkg::sample_t'($urandom);
    endcase
  endfunction

  function automatic arx_pkg::coef_t rand_extreme();
    case ($urandom_range(2))
      0:       return C_MAX;
      1:       return C_MIN;
      default: return '0;
    endcase
  endfunction

  // valid stays high after acceptance; it drops only for a gap or a drain
  task automatic send_sample(input arx_pkg::sample_t u);
    while ($urandom_range(99) < src_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid    <= 1'b1;
    in_u_sample <= u;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (y_waiting != 0);
  endtask

  task automatic write_reg(input logic [arx_pkg::CFG_IDX_W-1:0] idx,
                           input logic [arx_pkg::CFG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic load_filter(input bit poke_unused);
    int j;
    for (j = 0; j < arx_pkg::FB_REGS; j++)
      write_reg(arx_pkg::REG_FB_COEF_1 + arx_pkg::CFG_IDX_W'(j), fb_set[j]);
    for (j = 0; j < arx_pkg::FF_REGS; j++)
      write_reg(arx_pkg::REG_FF_COEF_0 + arx_pkg::CFG_IDX_W'(j), ff_set[j]);
    if (poke_unused) write_reg(REG_NONE, arx_pkg::CFG_DATA_W'($urandom));
    // upper data bits are don't-care for the delay register
    write_reg(arx_pkg::REG_INPUT_DELAY, {PAD_W'($urandom), delay_set});
    cfg_valid <= 1'b0;
  endtask

  task automatic pick_filter(input int mode);
    int j;
    for (j = 0; j < arx_pkg::FB_REGS; j++) begin
      case (mode)
        0:       fb_set[j] = arx_pkg::coef_t'(int'($urandom_range(4096)) - 2048);
        1:       fb_set[j] = arx_pkg::coef_t'($urandom);
        default: fb_set[j] = rand_extreme();
      endcase
    end
    for (j = 0; j < arx_pkg::FF_REGS; j++) begin
      case (mode)
        0:       ff_set[j] = arx_pkg::coef_t'(int'($urandom_range(8192)) - 4096);
        1:       ff_set[j] = arx_pkg::coef_t'($urandom);
        default: ff_set[j] = rand_extreme();
      endcase
    end
    if (mode == 2) begin
      delay_set = $urandom_range(1) ? arx_pkg::DELAY_W'(arx_pkg::MAX_DELAY_DEF) : '0;
    end else begin
      delay_set = arx_pkg::DELAY_W'($urandom_range(arx_pkg::MAX_DELAY_DEF));
    end
  endtask

  task automatic set_filter(input arx_pkg::coef_t fb_v, input arx_pkg::coef_t ff_v,
                            input arx_pkg::coef_t ff0_v,
                            input logic [arx_pkg::DELAY_W-1:0] dly);
    foreach (fb_set[j]) fb_set[j] = fb_v;
    foreach (ff_set[j]) ff_set[j] = ff_v;
    ff_set[0] = ff0_v;
    delay_set = dly;
  endtask

  initial begin
    int r;
    int p;
    int n;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // reset state: all coefficients zero, output must stay at zero
    send_sample(S_MAX);
    send_sample(S_MIN);

    // unity passthrough, plus a write to a nonexistent register
    drain();
    set_filter('0, '0, C_ONE, '0);
    load_filter(1'b1);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample('0);
    send_sample(16'sd1);
    send_sample(-16'sd1);

    // half gain puts odd inputs exactly on a rounding tie
    drain();
    set_filter('0, '0, 16'sh0800, '0);
    load_filter(1'b0);
    send_sample(16'sd1);
    send_sample(-16'sd1);
    send_sample(16'sd3);
    send_sample(-16'sd3);

    // longest delay applied to history already stored, heavy clipping
    drain();
    set_filter('0, '0, C_MAX, arx_pkg::DELAY_W'(arx_pkg::MAX_DELAY_DEF));
    fb_set[0] = C_MIN;
    load_filter(1'b0);
    send_sample(S_MAX);
    send_sample(S_MIN);
    send_sample(S_MAX);
    send_sample(S_MIN);

    drain();
    set_filter(C_MAX, C_MIN, C_MIN, '0);
    load_filter(1'b0);
    repeat (3) send_sample(S_MAX);
    repeat (3) send_sample(S_MIN);

    for (r = 0; r < 3; r++) begin
      case (r)
        0: begin
          src_idle_pct   = 15;
          sink_stall_pct <= 64;
        end
        1: begin
          src_idle_pct   = 64;
          sink_stall_pct <= 15;
        end
        default: begin
          src_idle_pct   = 0;
          sink_stall_pct <= 0;
        end
      endcase
      for (p = 0; p < 4; p++) begin
        drain();
        pick_filter((r + p) % 3);
        load_filter($urandom_range(3) == 0);
        // long receiver hold-off while requests keep coming
        if (r == 2 && p == 0) hold_req <= hold_req + 1;
        for (n = 0; n < PHASE_ITEMS; n++) send_sample(rand_sample());
      end
    end

    drain();
    repeat (4) @(posedge clk);
    if (mismatch_cnt == 0 && y_waiting == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule
